@@ rtl/nth_substring_match_finder_defines.svh @@
// Assertion macros shared by the checker of the substring match finder.
// Depends on nothing; each macro expects clk and rst in scope.
`ifndef NTH_SUBSTRING_MATCH_FINDER_DEFINES_SVH
`define NTH_SUBSTRING_MATCH_FINDER_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define NSMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define NSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/nsmf_pkg.sv @@
// Package of the substring match finder: configuration and result types,
// register indexes and field widths. Depends on nothing.
package nsmf_pkg;

  localparam int BYTE_W = 8;
  localparam int POS_W = 13;
  localparam int REG_INDEX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_BYTES = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_SKIP_COUNT = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_REPORT_END = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_START_LIMIT = 3'd4;

  typedef struct packed {
    logic [63:0] pattern_bytes;
    logic [3:0] pattern_length;
    logic [15:0] skip_count;
    logic report_end;
    logic [POS_W-1:0] start_limit;
  } cfg_t;

  typedef struct packed {
    logic found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

@@ rtl/nsmf_in_stage.sv @@
// Input register of the substring match finder with its flow control.
// Depends on nsmf_pkg.
module nsmf_in_stage (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [nsmf_pkg::BYTE_W-1:0] s_tdata,
  input  logic s_tlast,
  input  logic res_free,
  output logic advance,
  output logic [nsmf_pkg::BYTE_W-1:0] text_byte,
  output logic last_byte
);

  logic held;

  // A held item moves on unless it needs the result register and that is full.
  assign advance = held && (!last_byte || res_free);
  assign s_tready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tready) begin
      held <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      text_byte <= s_tdata;
      last_byte <= s_tlast;
    end
  end

endmodule

@@ rtl/nsmf_scan.sv @@
// Byte window, pattern compare and occurrence tracking of the match finder.
// Depends on nsmf_pkg.
module nsmf_scan #(
  parameter int PATTERN_MAX = 8,
  parameter int TEXT_MAX = 4096
) (
  input  logic clk,
  input  logic rst,
  input  nsmf_pkg::cfg_t cfg,
  input  logic advance,
  input  logic [nsmf_pkg::BYTE_W-1:0] text_byte,
  input  logic last_byte,
  output nsmf_pkg::result_t result
);

  localparam int PW = $clog2(TEXT_MAX + 1);
  localparam int CW = ((PW > nsmf_pkg::POS_W) ? PW : nsmf_pkg::POS_W) + 1;
  localparam int WI = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [PW-1:0] TEXT_END = PW'(TEXT_MAX);
  localparam logic [3:0] LEN_MAX = 4'(PATTERN_MAX);

  logic [nsmf_pkg::BYTE_W-1:0] window [PATTERN_MAX];
  logic [nsmf_pkg::BYTE_W-1:0] window_next [PATTERN_MAX];
  logic [PW-1:0] byte_position;
  logic [PW-1:0] byte_position_next;
  logic [15:0] skips_left;
  logic [15:0] skips_left_next;
  logic match_seen;
  logic match_seen_next;
  logic [nsmf_pkg::POS_W-1:0] match_position;
  logic [nsmf_pkg::POS_W-1:0] match_position_next;

  logic [3:0] len_eff;
  logic [3:0] diff;
  logic [WI-1:0] idx;
  logic window_hit;
  logic [CW-1:0] pos_plus1;
  logic [CW-1:0] start;
  logic in_range;
  logic below_limit;
  logic counted;
  logic [15:0] skips_cur;

  always_comb begin
    window_next[0] = text_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  assign len_eff = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;

  // The newest byte sits at entry 0, so pattern byte c meets entry len-1-c.
  always_comb begin
    window_hit = 1'b1;
    diff = '0;
    idx = '0;
    for (int c = 0; c < PATTERN_MAX; c++) begin
      diff = len_eff - 4'(c) - 4'd1;
      idx = diff[WI-1:0];
      if ((4'(c) < len_eff) &&
          (window_next[idx] != cfg.pattern_bytes[8*c +: 8])) begin
        window_hit = 1'b0;
      end
    end
  end

  assign pos_plus1 = CW'(byte_position) + CW'(1);
  assign start = pos_plus1 - CW'(len_eff);
  assign in_range = (byte_position != TEXT_END) && (pos_plus1 >= CW'(len_eff));
  assign below_limit = (cfg.start_limit == '0) || (start < CW'(cfg.start_limit));
  assign counted = (len_eff != 4'd0) && in_range && !match_seen && window_hit &&
                   below_limit;
  assign skips_cur = (byte_position == '0) ? cfg.skip_count : skips_left;

  always_comb begin
    skips_left_next = skips_cur;
    match_seen_next = match_seen;
    match_position_next = match_position;
    if (counted) begin
      if (skips_cur != 16'd0) begin
        skips_left_next = skips_cur - 16'd1;
      end else begin
        match_seen_next = 1'b1;
        match_position_next = cfg.report_end ? pos_plus1[nsmf_pkg::POS_W-1:0]
                                             : start[nsmf_pkg::POS_W-1:0];
      end
    end
    byte_position_next = (byte_position == TEXT_END) ? byte_position
                                                     : byte_position + PW'(1);
  end

  always_comb begin
    result.found = match_seen_next;
    result.position = match_seen_next ? match_position_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= '0;
      end
      byte_position <= '0;
      skips_left <= '0;
      match_seen <= 1'b0;
      match_position <= '0;
    end else if (advance) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= window_next[k];
      end
      byte_position <= byte_position_next;
      skips_left <= skips_left_next;
      match_seen <= match_seen_next;
      match_position <= match_position_next;
    end
  end

endmodule

@@ rtl/nth_substring_match_finder.sv @@
// Top level of the substring match finder: configuration registers,
// input stage, scan unit and result register. Depends on nsmf_pkg,
// nsmf_in_stage and nsmf_scan.
//
// The text streams in one byte per item on the s_ channel, s_tlast on the
// final byte. The pattern (1 to 8 bytes), the number of occurrences to pass
// over, the start limit and the start/end selection are written through
// cfg_we, cfg_index and cfg_data while no text is in flight.
// Only the final byte of a text produces an item on the m_ channel:
// m_tuser is set when the wanted occurrence exists and m_tdata then holds
// its start, or its end when the end is selected, and zero otherwise.
// The block takes one byte every cycle while s_tready is high. The byte goes
// from the input register through the window compare into the result
// register, from which the result is shown on the m_ channel.
// When the receiver stalls, the result waits in the output register and bytes
// keep flowing until a second final byte arrives; that byte waits in the
// input register and s_tready drops until the result is taken.
// Reset empties both registers, clears the window and the tally, and loads the
// register defaults (pattern length one, everything else zero).
module nth_substring_match_finder #(
  parameter int PATTERN_MAX = 8,
  parameter int TEXT_MAX = 4096
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic s_tlast,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [15:0] m_tdata,  // [12:0] position, [15:13] zero
  output logic m_tuser,         // [0] found
  input  logic cfg_we,
  input  logic [nsmf_pkg::REG_INDEX_W-1:0] cfg_index,
  input  logic [nsmf_pkg::CFG_DATA_W-1:0] cfg_data
);

  nsmf_pkg::cfg_t cfg;
  nsmf_pkg::result_t result;
  nsmf_pkg::result_t out_reg;
  logic res_free;
  logic advance;
  logic [nsmf_pkg::BYTE_W-1:0] text_byte;
  logic last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes <= '0;
      cfg.pattern_length <= 4'd1;
      cfg.skip_count <= '0;
      cfg.report_end <= 1'b0;
      cfg.start_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nsmf_pkg::REG_PATTERN_BYTES:  cfg.pattern_bytes <= cfg_data;
        nsmf_pkg::REG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[3:0];
        nsmf_pkg::REG_SKIP_COUNT:     cfg.skip_count <= cfg_data[15:0];
        nsmf_pkg::REG_REPORT_END:     cfg.report_end <= cfg_data[0];
        nsmf_pkg::REG_START_LIMIT:    cfg.start_limit <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  assign res_free = !m_tvalid || m_tready;

  nsmf_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .res_free  (res_free),
    .advance   (advance),
    .text_byte (text_byte),
    .last_byte (last_byte)
  );

  nsmf_scan #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .advance   (advance),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && last_byte) begin
      out_reg <= result;
    end
  end

  assign m_tuser = out_reg.found;
  assign m_tdata = 16'(out_reg.position);

endmodule

@@ rtl/nsmf_checker.sv @@
// Port-level checker of the substring match finder, bound to the top level.
// Depends on nth_substring_match_finder_defines.svh.
`include "nth_substring_match_finder_defines.svh"

module nsmf_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic [7:0] s_tdata,
  input logic s_tlast,
  input logic m_tvalid,
  input logic m_tready,
  input logic [15:0] m_tdata,
  input logic m_tuser
);

  `NSMF_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `NSMF_ASSERT_NOW(a_stall_only_when_blocked, !s_tready, m_tvalid && !m_tready, "input stalled without a blocked result")
  `NSMF_ASSERT_NOW(a_reset_clears, $past(rst), s_tready && !m_tvalid, "not idle after reset")
  `NSMF_ASSERT_NOW(a_not_found_zero, m_tvalid && !m_tuser, m_tdata == 16'd0, "position nonzero without a match")

endmodule

bind nth_substring_match_finder nsmf_checker u_nsmf_checker (.*);
